// ===== hw/rtl/vn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants and helpers for the 3D vector normalize unit.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int IN_BITS            = 32;
  localparam int LENGTH_BITS        = 32;
  localparam int DEF_COMPONENT_BITS = 32;
  localparam int DEF_FRACTION_BITS  = 16;
  localparam int NUM_LANES          = 3;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/vn_delay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_delay
// Fixed-depth shift line used to align side data with the pipelines.
// ----------------------------------------------------------------------------
module vn_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  generate
    if (DEPTH == 0) begin : g_none
      assign d_o = d_i;
    end else begin : g_line
      logic [W-1:0] sr_r [DEPTH];
      always_ff @(posedge clk) begin
        sr_r[0] <= d_i;
        for (int i = 1; i < DEPTH; i++) begin
          sr_r[i] <= sr_r[i-1];
        end
      end
      assign d_o = sr_r[DEPTH-1];
    end
  endgenerate

endmodule

// ===== hw/rtl/vn_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined integer square root, one result bit per stage (W/2 stages).
// ----------------------------------------------------------------------------
module vn_sqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic [W-1:0]   rad_i,
  output logic [W/2-1:0] root_o
);

  localparam int N  = W / 2;
  localparam int RW = N + 2;

  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [W-1:0]  dat_r  [N];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      logic [RW-1:0] rin, rsh, trial;
      logic [N-1:0]  qin;
      logic [W-1:0]  din;
      logic          ge;

      if (g == 0) begin : g_first
        assign rin = '0;
        assign qin = '0;
        assign din = rad_i;
      end else begin : g_next
        assign rin = rem_r[g-1];
        assign qin = root_r[g-1];
        assign din = dat_r[g-1];
      end

      // bring down the next bit pair, try root*4+1
      always_comb begin
        rsh   = {rin[RW-3:0], din[W-1:W-2]};
        trial = {qin, 2'b01};
        ge    = (rsh >= trial);
      end

      always_ff @(posedge clk) begin
        rem_r[g]  <= ge ? (rsh - trial) : rsh;
        root_r[g] <= N'({qin, ge});
        dat_r[g]  <= din << 2;
      end
    end
  endgenerate

  assign root_o = root_r[N-1];

endmodule

// ===== hw/rtl/vn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div
// Pipelined fractional divider: floor(num * 2^(QB-1) / den), num <= den.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div #(
  parameter int NW = 64,
  parameter int QB = 33
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  logic [NW-1:0] rem_r [QB];
  logic [NW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];

  genvar g;
  generate
    for (g = 0; g < QB; g++) begin : g_stage
      logic [NW:0]   sh;
      logic [NW:0]   dx;
      logic [NW-1:0] dcur;
      logic [QB-1:0] qin;
      logic          ge;

      if (g == 0) begin : g_first
        // integer bit: num <= den, so it is 1 only on equality
        assign sh   = {1'b0, num_i};
        assign dcur = den_i;
        assign qin  = '0;
      end else begin : g_next
        assign sh   = {rem_r[g-1], 1'b0};
        assign dcur = den_r[g-1];
        assign qin  = quo_r[g-1];
      end

      always_comb begin
        dx = {1'b0, dcur};
        ge = (sh >= dx);
      end

      always_ff @(posedge clk) begin
        rem_r[g] <= ge ? NW'(sh - dx) : NW'(sh);
        den_r[g] <= dcur;
        quo_r[g] <= QB'({qin, ge});
      end
    end
  endgenerate

  assign quo_o = quo_r[QB-1];

endmodule

// ===== hw/rtl/vn_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_lane
// One component lane: sqrt(c^2 * 2^(2F) / sum) with the sign put back.
// Divider stages, then square-root stages, then a registered sign fix.
// ----------------------------------------------------------------------------
module vn_lane #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic [2*CB-1:0]      sq_i,
  input  logic [2*CB-1:0]      sum_i,
  input  logic                 neg_i,
  output logic signed [FB+1:0] unit_o
);

  localparam int QB = 2*FB + 1;
  localparam int RB = 2*FB + 2;

  logic [QB-1:0]   quo;
  logic [FB:0]     root;
  logic            neg_d;
  logic [FB+1:0]   mag_ext;
  logic [FB+1:0]   unit_r, unit_nxt;

  vn_div #(.NW(2*CB), .QB(QB)) u_div (
    .clk   (clk),
    .num_i (sq_i),
    .den_i (sum_i),
    .quo_o (quo)
  );

  vn_sqrt #(.W(RB)) u_sqrt (
    .clk    (clk),
    .rad_i  (RB'(quo)),
    .root_o (root)
  );

  vn_delay #(.W(1), .DEPTH(QB + FB + 1)) u_neg_dly (
    .clk (clk),
    .d_i (neg_i),
    .d_o (neg_d)
  );

  always_comb begin
    mag_ext  = (FB+2)'(root);
    unit_nxt = neg_d ? (~mag_ext + (FB+2)'(1)) : mag_ext;
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
  end

  assign unit_o = signed'(unit_r);

endmodule

// ===== hw/rtl/vector_normalize_3d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_3d_unit
// Unit vector and Euclidean length of a signed fixed-point 3D vector.
// Datapath: magnitude, square and sum registers, then the lane pipelines
//   and the length square root, aligned by delay lines, then a merge register.
// Throughput: one word per cycle; busy is held low.
// Reset clears the valid pipeline only; datapath registers are not reset.
// ----------------------------------------------------------------------------
module vector_normalize_3d_unit
  import vn_pkg::*;
#(
  parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [IN_BITS-1:0]      in_vec_x,
  input  logic signed [IN_BITS-1:0]      in_vec_y,
  input  logic signed [IN_BITS-1:0]      in_vec_z,
  output logic                           out_valid,
  output logic signed [FRACTION_BITS+1:0] out_unit_x,
  output logic signed [FRACTION_BITS+1:0] out_unit_y,
  output logic signed [FRACTION_BITS+1:0] out_unit_z,
  output logic [LENGTH_BITS-1:0]         out_vec_length,
  output logic                           out_zero_vector
);

  localparam int CB       = COMPONENT_BITS;
  localparam int FB       = FRACTION_BITS;
  localparam int UB       = FB + 2;
  localparam int LANE_LAT = 3*FB + 3;
  localparam int CORE_LAT = max_int(LANE_LAT, CB);
  localparam int VDEPTH   = 3 + CORE_LAT;
  localparam int UNIT_ONE = 1 << FB;

  logic [IN_BITS-1:0] vin [NUM_LANES];
  logic [CB-1:0]      mag_r [NUM_LANES];
  logic               neg1_r [NUM_LANES];
  logic [2*CB-1:0]    sq_r [NUM_LANES];
  logic               neg2_r [NUM_LANES];
  logic [2*CB-1:0]    sq3_r [NUM_LANES];
  logic               neg3_r [NUM_LANES];
  logic [2*CB-1:0]    sum_r;
  logic [VDEPTH-1:0]  vld_r;

  logic signed [UB-1:0] lane_unit [NUM_LANES];
  logic signed [UB-1:0] unit_al   [NUM_LANES];
  logic [CB-1:0]        len_root, len_al;
  logic                 zero_al;

  logic                 out_valid_r;
  logic signed [UB-1:0] unit_r [NUM_LANES];
  logic [LENGTH_BITS-1:0] len_r;
  logic                 zero_r;
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vin[0] = in_vec_x;
  assign vin[1] = in_vec_y;
  assign vin[2] = in_vec_z;

  genvar k;
  generate
    for (k = 0; k < NUM_LANES; k++) begin : g_lane
      logic [CB-1:0] comp, mag_nxt;
      logic          neg_nxt;

      // two's complement magnitude; the most negative value stays in range
      always_comb begin
        comp    = vin[k][CB-1:0];
        neg_nxt = comp[CB-1];
        mag_nxt = neg_nxt ? (~comp + CB'(1)) : comp;
      end

      always_ff @(posedge clk) begin
        mag_r[k]  <= mag_nxt;
        neg1_r[k] <= neg_nxt;
        sq_r[k]   <= (2*CB)'(mag_r[k]) * (2*CB)'(mag_r[k]);
        neg2_r[k] <= neg1_r[k];
        sq3_r[k]  <= sq_r[k];
        neg3_r[k] <= neg2_r[k];
      end

      vn_lane #(.CB(CB), .FB(FB)) u_lane (
        .clk    (clk),
        .sq_i   (sq3_r[k]),
        .sum_i  (sum_r),
        .neg_i  (neg3_r[k]),
        .unit_o (lane_unit[k])
      );

      vn_delay #(.W(UB), .DEPTH(CORE_LAT - LANE_LAT)) u_unit_dly (
        .clk (clk),
        .d_i (lane_unit[k]),
        .d_o (unit_al[k])
      );
    end
  endgenerate

  // sum of three squares fits 2*CB bits
  always_ff @(posedge clk) begin
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  vn_sqrt #(.W(2*CB)) u_len_sqrt (
    .clk    (clk),
    .rad_i  (sum_r),
    .root_o (len_root)
  );

  vn_delay #(.W(CB), .DEPTH(CORE_LAT - CB)) u_len_dly (
    .clk (clk),
    .d_i (len_root),
    .d_o (len_al)
  );

  vn_delay #(.W(1), .DEPTH(CORE_LAT)) u_zero_dly (
    .clk (clk),
    .d_i (sum_r == '0),
    .d_o (zero_al)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[VDEPTH-2:0], accept};
      out_valid_r <= vld_r[VDEPTH-1];
    end
  end

  // merge: zero vector forces all results to zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      unit_r[i] <= zero_al ? '0 : unit_al[i];
    end
    len_r  <= zero_al ? '0 : LENGTH_BITS'(len_al);
    zero_r <= zero_al;
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_vec_length  = len_r;
  assign out_zero_vector = zero_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, VDEPTH + 1))
    else $error("result word without matching input word");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_vec_length == '0 && out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0))
    else $error("zero vector with nonzero results");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_unit_x <= UNIT_ONE && out_unit_x >= -UNIT_ONE))
    else $error("unit component out of range");

endmodule
